>>> hw/rtl/sat_at_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_at_pkg: shared types and codes of the assignment trail
// Beat layouts of the command and response channels, command, status and
// literal state codes, and the fixed field widths.
// ----------------------------------------------------------------------------
package sat_at_pkg;

  localparam int unsigned VAR_BITS    = 10;
  localparam int unsigned LEVEL_BITS  = 11;
  localparam int unsigned CLAUSE_BITS = 16;
  localparam int unsigned RECIP_SHIFT = 2 * VAR_BITS;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_POP    = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_SKIPPED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    LIT_UNASSIGNED = 2'd0,
    LIT_TRUE       = 2'd1,
    LIT_FALSE      = 2'd2
  } lit_e;

  typedef struct packed {
    logic [1:0]             command;
    logic                   decision;
    logic                   lit_en;
    logic [VAR_BITS-1:0]    var_index;
    logic                   polarity;
    logic [CLAUSE_BITS-1:0] clause_tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   act_is_decision;
    logic                   act_has_literal;
    logic [VAR_BITS-1:0]    act_var;
    logic                   act_polarity;
    logic [CLAUSE_BITS-1:0] act_clause;
    logic [1:0]             lit_state;
    logic [LEVEL_BITS-1:0]  var_level;
    logic                   saved_negative;
    logic [LEVEL_BITS-1:0]  decision_level;
    logic [LEVEL_BITS-1:0]  trail_length;
  } rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/sat_at_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_at_if: command and response channels of the assignment trail
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sat_at_cmd_if import sat_at_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sat_at_rsp_if import sat_at_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sat_at_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_at_ram: simple dual-port memory with bit write mask
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sat_at_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wmask_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) begin
          mem[waddr_i][i] <= wdata_i[i];
        end
      end
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/sat_at_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_at_ctrl: sequencer of the assignment trail
// Reads the trail and variable memories, applies append, pop and query,
// writes back and registers the response beat. Clears the variable table
// after reset.
// ----------------------------------------------------------------------------
module sat_at_ctrl import sat_at_pkg::*; #(
  parameter int unsigned VAR_COUNT      = 1024,
  parameter int unsigned TRAIL_DEPTH    = 1024,
  parameter int unsigned CLAUSE_ID_BITS = 16,
  localparam int unsigned VW   = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1,
  localparam int unsigned AW   = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1,
  localparam int unsigned TW   = $clog2(TRAIL_DEPTH + 1),
  localparam int unsigned TE_W = 3 + VAR_BITS + CLAUSE_ID_BITS,
  localparam int unsigned VE_W = 2 + LEVEL_BITS + AW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  sat_at_cmd_if.sink           cmd_i,
  sat_at_rsp_if.source         rsp_o,
  output      logic            tr_we_o,
  output      logic [AW-1:0]   tr_waddr_o,
  output      logic [TE_W-1:0] tr_wdata_o,
  output      logic [AW-1:0]   tr_raddr_o,
  input  wire logic [TE_W-1:0] tr_rdata_i,
  output      logic            vr_we_o,
  output      logic [VW-1:0]   vr_waddr_o,
  output      logic [VE_W-1:0] vr_wmask_o,
  output      logic [VE_W-1:0] vr_wdata_o,
  output      logic [VW-1:0]   vr_raddr_o,
  input  wire logic [VE_W-1:0] vr_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_CAUSE
  } state_e;

  state_e                state_q, state_d;
  logic [VW-1:0]         clr_q, clr_d;
  cmd_t                  cmd_q, cmd_d;
  logic [TW-1:0]         top_q, top_d;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic                  rsp_valid_q, rsp_valid_d;
  rsp_t                  rsp_q, rsp_d;

  logic                  cmd_ready;
  logic                  finish;
  logic                  go;
  rsp_t                  res;
  logic [VAR_BITS-1:0]   v;
  logic [VW-1:0]         va;
  logic [LEVEL_BITS-1:0] level_inc;
  logic [LEVEL_BITS-1:0] level_dec;

  logic                      tr_dec;
  logic                      tr_lit;
  logic [VAR_BITS-1:0]       tr_var;
  logic                      tr_neg;
  logic [CLAUSE_ID_BITS-1:0] tr_clause;

  logic                  ve_asg;
  logic                  ve_neg;
  logic [LEVEL_BITS-1:0] ve_level;
  logic [AW-1:0]         ve_cause;

  assign tr_dec    = tr_rdata_i[TE_W-1];
  assign tr_lit    = tr_rdata_i[TE_W-2];
  assign tr_var    = tr_rdata_i[TE_W-3 -: VAR_BITS];
  assign tr_neg    = tr_rdata_i[CLAUSE_ID_BITS];
  assign tr_clause = tr_rdata_i[CLAUSE_ID_BITS-1:0];

  assign ve_asg   = vr_rdata_i[VE_W-1];
  assign ve_neg   = vr_rdata_i[VE_W-2];
  assign ve_level = vr_rdata_i[VE_W-3 -: LEVEL_BITS];
  assign ve_cause = vr_rdata_i[AW-1:0];

  // reduce the variable index into the table range
  if (VAR_COUNT >= (1 << VAR_BITS)) begin : g_wide
    assign v = cmd_q.var_index;
  end else begin : g_reduce
    localparam int unsigned RECIP =
      ((32'd1 << RECIP_SHIFT) + VAR_COUNT - 1) / VAR_COUNT;

    logic [RECIP_SHIFT+VAR_BITS-1:0] prod;
    logic [VAR_BITS-1:0]             quo_q;
    logic [RECIP_SHIFT-1:0]          back;

    assign prod = (RECIP_SHIFT + VAR_BITS)'(cmd_i.data.var_index)
                * (RECIP_SHIFT + VAR_BITS)'(RECIP);

    always_ff @(posedge clk_i) begin
      if (cmd_ready && cmd_i.valid) begin
        quo_q <= prod[RECIP_SHIFT+VAR_BITS-1:RECIP_SHIFT];
      end
    end

    assign back = RECIP_SHIFT'(quo_q) * RECIP_SHIFT'(VAR_COUNT);
    assign v    = cmd_q.var_index - back[VAR_BITS-1:0];
  end

  assign va         = VW'(v);
  assign vr_raddr_o = va;
  assign tr_raddr_o = (cmd_q.command == CMD_QUERY) ? ve_cause : AW'(top_q - 1'b1);
  assign tr_waddr_o = top_q[AW-1:0];
  assign tr_wdata_o = {cmd_q.decision, cmd_q.lit_en,
                       cmd_q.lit_en ? v : {VAR_BITS{1'b0}},
                       cmd_q.lit_en & cmd_q.polarity,
                       CLAUSE_ID_BITS'(cmd_q.clause_tag)};

  assign go        = !rsp_valid_q || rsp_o.ready;
  assign level_inc = (cmd_q.decision && level_q != LEVEL_MAX) ? level_q + 1'b1 : level_q;
  assign level_dec = (tr_dec && level_q != '0) ? level_q - 1'b1 : level_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    top_d       = top_q;
    level_d     = level_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    cmd_ready   = 1'b0;
    finish      = 1'b0;
    res         = '0;
    tr_we_o     = 1'b0;
    vr_we_o     = 1'b0;
    vr_waddr_o  = va;
    vr_wmask_o  = '1;
    vr_wdata_o  = {1'b1, cmd_q.polarity, level_inc, top_q[AW-1:0]};

    unique case (state_q)
      ST_CLEAR: begin
        vr_we_o    = 1'b1;
        vr_waddr_o = clr_q;
        vr_wdata_o = '0;
        if (clr_q == VW'(VAR_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cmd_q.command == CMD_QUERY && ve_asg) begin
          state_d = ST_CAUSE;
        end else if (go) begin
          finish    = 1'b1;
          cmd_ready = 1'b1;
          unique case (cmd_e'(cmd_q.command))
            CMD_APPEND: begin
              if (cmd_q.lit_en && ve_asg) begin
                res.status = STAT_SKIPPED;
              end else if (top_q == TW'(TRAIL_DEPTH)) begin
                res.status = STAT_FULL;
              end else begin
                tr_we_o = 1'b1;
                vr_we_o = cmd_q.lit_en;
                top_d   = top_q + 1'b1;
                level_d = level_inc;
              end
            end
            CMD_POP: begin
              if (top_q == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                // clear only the assigned flag, keep phase and level
                vr_we_o             = tr_lit;
                vr_waddr_o          = VW'(tr_var);
                vr_wmask_o          = '0;
                vr_wmask_o[VE_W-1]  = 1'b1;
                vr_wdata_o          = '0;
                top_d               = top_q - 1'b1;
                level_d             = level_dec;
                res.act_is_decision = tr_dec;
                res.act_has_literal = tr_lit;
                res.act_var         = tr_var;
                res.act_polarity    = tr_neg;
                res.act_clause      = CLAUSE_BITS'(tr_clause);
              end
            end
            CMD_QUERY: begin
              res.lit_state      = LIT_UNASSIGNED;
              res.var_level      = ve_level;
              res.saved_negative = ve_neg;
            end
            CMD_NONE: begin
              res.status = STAT_OK;
            end
          endcase
        end
      end
      ST_CAUSE: begin
        if (go) begin
          finish              = 1'b1;
          cmd_ready           = 1'b1;
          res.lit_state       = (ve_neg == cmd_q.polarity) ? LIT_TRUE : LIT_FALSE;
          res.var_level       = ve_level;
          res.saved_negative  = ve_neg;
          res.act_is_decision = tr_dec;
          res.act_has_literal = tr_lit;
          res.act_var         = tr_var;
          res.act_polarity    = tr_neg;
          res.act_clause      = CLAUSE_BITS'(tr_clause);
        end
      end
    endcase

    if (finish) begin
      res.decision_level = level_d;
      res.trail_length   = LEVEL_BITS'(top_d);
      rsp_d              = res;
      rsp_valid_d        = 1'b1;
    end

    if (cmd_ready && cmd_i.valid) begin
      cmd_d   = cmd_i.data;
      state_d = ST_READ;
    end else if (finish) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cmd_q       <= '0;
      top_q       <= '0;
      level_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cmd_q       <= cmd_d;
      top_q       <= top_d;
      level_q     <= level_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign cmd_i.ready = cmd_ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule
`default_nettype wire

>>> hw/rtl/sat_assignment_trail_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sat_assignment_trail_top: assignment trail of a CDCL SAT solver
// Action stack plus per-variable assignment, level, saved phase and cause.
//
// Usage:
//   cmd_i carries one command beat: append an action, pop the top action,
//   query a literal or do nothing; rsp_o returns exactly one response beat
//   per command, in order, with status, popped or cause action, literal state
//   and the decision level and trail length after the command.
//   Sequence: append, pop and an unassigned query pass a read step and an
//   update step before the response is registered; a query of an assigned
//   variable adds a cause step, reading the variable table and then the trail
//   entry of its cause. A new command is taken in the cycle the response is
//   registered, not while one is still in its steps; the pace is set by the
//   read-then-write of the memories.
//   Reset: after rst_ni rises, a clearing pass writes every entry of the
//   variable table with cmd_i.ready low; the trail starts empty.
//   Stall: the response waits in an output register while rsp_o.ready is
//   low; a command taken meanwhile holds in its update or cause step, with
//   cmd_i.ready low, until that register can take its result.
// ----------------------------------------------------------------------------
module sat_assignment_trail_top import sat_at_pkg::*; #(
  parameter int unsigned VAR_COUNT      = 1024,
  parameter int unsigned TRAIL_DEPTH    = 1024,
  parameter int unsigned CLAUSE_ID_BITS = 16
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  sat_at_cmd_if.sink   cmd_i,
  sat_at_rsp_if.source rsp_o
);

  localparam int unsigned VW   = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int unsigned AW   = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int unsigned TE_W = 3 + VAR_BITS + CLAUSE_ID_BITS;
  localparam int unsigned VE_W = 2 + LEVEL_BITS + AW;

  logic            tr_we;
  logic [AW-1:0]   tr_waddr;
  logic [TE_W-1:0] tr_wdata;
  logic [AW-1:0]   tr_raddr;
  logic [TE_W-1:0] tr_rdata;
  logic            vr_we;
  logic [VW-1:0]   vr_waddr;
  logic [VE_W-1:0] vr_wmask;
  logic [VE_W-1:0] vr_wdata;
  logic [VW-1:0]   vr_raddr;
  logic [VE_W-1:0] vr_rdata;

  sat_at_ctrl #(
    .VAR_COUNT      (VAR_COUNT),
    .TRAIL_DEPTH    (TRAIL_DEPTH),
    .CLAUSE_ID_BITS (CLAUSE_ID_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .rsp_o      (rsp_o),
    .tr_we_o    (tr_we),
    .tr_waddr_o (tr_waddr),
    .tr_wdata_o (tr_wdata),
    .tr_raddr_o (tr_raddr),
    .tr_rdata_i (tr_rdata),
    .vr_we_o    (vr_we),
    .vr_waddr_o (vr_waddr),
    .vr_wmask_o (vr_wmask),
    .vr_wdata_o (vr_wdata),
    .vr_raddr_o (vr_raddr),
    .vr_rdata_i (vr_rdata)
  );

  sat_at_ram #(
    .WIDTH (TE_W),
    .DEPTH (TRAIL_DEPTH)
  ) u_trail_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wmask_i ({TE_W{1'b1}}),
    .wdata_i (tr_wdata),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  sat_at_ram #(
    .WIDTH (VE_W),
    .DEPTH (VAR_COUNT)
  ) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (vr_we),
    .waddr_i (vr_waddr),
    .wmask_i (vr_wmask),
    .wdata_i (vr_wdata),
    .raddr_i (vr_raddr),
    .rdata_o (vr_rdata)
  );

endmodule
`default_nettype wire

>>> tb/sat_assignment_trail_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_assignment_trail_top_tb: self-checking bench for the assignment trail
// Drives append, pop, query and unknown commands through the valid/ready
// command channel. An in-bench trail and variable table predicts every
// response, which the monitor compares field by field in order. Runs a
// directed opening, then random traffic under three idling mixes, and
// includes a fill to trail full and a partial unwind.
// ----------------------------------------------------------------------------
module sat_assignment_trail_top_tb;
  import sat_at_pkg::*;

  localparam int unsigned VAR_COUNT   = 1024;
  localparam int unsigned TRAIL_DEPTH = 1024;
  localparam int unsigned RANDOM_ITEMS = 16;
  localparam int unsigned UNWIND_ITEMS = 32;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef struct packed {
    bit                   dec;
    bit                   lit;
    bit [VAR_BITS-1:0]    vidx;
    bit                   neg;
    bit [CLAUSE_BITS-1:0] clause;
  } trail_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sat_at_cmd_if cmd_if ();
  sat_at_rsp_if rsp_if ();

  sat_assignment_trail_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];
  rsp_t rsp_head;

  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  // Trail and variable table as the block should hold them.
  trail_entry_t               trail_mem [TRAIL_DEPTH];
  int unsigned                trail_top = 0;
  int unsigned                cur_level = 0;
  bit                         var_set   [VAR_COUNT];
  bit                         var_neg   [VAR_COUNT];
  bit [LEVEL_BITS-1:0]        var_lvl   [VAR_COUNT];
  bit                         var_phase [VAR_COUNT];
  int unsigned                var_cause [VAR_COUNT];
  bit                         fill_taken [VAR_COUNT];

  function automatic rsp_t with_action(rsp_t r, trail_entry_t e);
    r.act_is_decision = e.dec;
    r.act_has_literal = e.lit;
    r.act_var         = e.vidx;
    r.act_polarity    = e.neg;
    r.act_clause      = e.clause;
    return r;
  endfunction

  function automatic rsp_t trail_apply(cmd_t c);
    rsp_t         r;
    trail_entry_t e;
    int unsigned  v;
    r = '0;
    v = c.var_index % VAR_COUNT;
    case (c.command)
      CMD_APPEND: begin
        if (c.lit_en && var_set[v]) begin
          r.status = STAT_SKIPPED;
        end else if (trail_top >= TRAIL_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (c.decision && cur_level < LEVEL_MAX) cur_level++;
          e.dec    = c.decision;
          e.lit    = c.lit_en;
          e.vidx   = c.lit_en ? VAR_BITS'(v) : '0;
          e.neg    = c.lit_en ? c.polarity : 1'b0;
          e.clause = c.clause_tag;
          if (c.lit_en) begin
            var_set[v]   = 1'b1;
            var_neg[v]   = c.polarity;
            var_phase[v] = c.polarity;
            var_lvl[v]   = LEVEL_BITS'(cur_level);
            var_cause[v] = trail_top;
          end
          trail_mem[trail_top] = e;
          trail_top++;
        end
      end
      CMD_POP: begin
        if (trail_top == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          trail_top--;
          e = trail_mem[trail_top];
          if (e.lit) var_set[e.vidx % VAR_COUNT] = 1'b0;
          if (e.dec && cur_level > 0) cur_level--;
          r = with_action(r, e);
        end
      end
      CMD_QUERY: begin
        if (var_set[v]) begin
          r.lit_state = (var_neg[v] == c.polarity) ? LIT_TRUE : LIT_FALSE;
          r = with_action(r, trail_mem[var_cause[v]]);
        end
        r.var_level      = var_lvl[v];
        r.saved_negative = var_phase[v];
      end
      default: ;
    endcase
    r.decision_level = LEVEL_BITS'(cur_level);
    r.trail_length   = LEVEL_BITS'(trail_top);
    return r;
  endfunction

  function automatic cmd_t make_cmd(cmd_e op, bit dec, bit lit, int unsigned vi, bit pol,
                                    int unsigned cl);
    cmd_t c;
    c.command    = op;
    c.decision   = dec;
    c.lit_en     = lit;
    c.var_index  = VAR_BITS'(vi);
    c.polarity   = pol;
    c.clause_tag = CLAUSE_BITS'(cl);
    return c;
  endfunction

  function automatic logic [VAR_BITS-1:0] pick_var();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return VAR_BITS'($urandom_range(15));
    if (roll < 60) return '0;
    if (roll < 65) return '1;
    return VAR_BITS'($urandom());
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned roll;
    roll = $urandom_range(99);
    c.decision   = $urandom_range(1);
    c.lit_en     = $urandom_range(1);
    c.polarity   = $urandom_range(1);
    c.clause_tag = CLAUSE_BITS'($urandom());
    c.var_index  = pick_var();
    if (roll < 45) begin
      c.command  = CMD_APPEND;
      c.lit_en   = ($urandom_range(99) < 85);
      c.decision = ($urandom_range(99) < 40);
    end else if (roll < 75) begin
      c.command = CMD_POP;
    end else if (roll < 97) begin
      c.command = CMD_QUERY;
    end else begin
      c.command = CMD_NONE;
    end
    return c;
  endfunction

  task automatic enqueue(input cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_rsps.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) enqueue(random_cmd());
  endtask

  // Command driver: predict on each accepted beat, then load the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.data  <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_rsps.insert(expected_rsps.size(), trail_apply(cmd_if.data));
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_if.valid <= 1'b1;
          cmd_if.data  <= pending_cmds.pop_front();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none got %h", $time, rsp_if.data);
          mismatch_count++;
        end else begin
          rsp_head = expected_rsps.pop_front();
          check_field("status", rsp_head.status, rsp_if.data.status);
          check_field("act_is_decision", rsp_head.act_is_decision,
                      rsp_if.data.act_is_decision);
          check_field("act_has_literal", rsp_head.act_has_literal,
                      rsp_if.data.act_has_literal);
          check_field("act_var", rsp_head.act_var, rsp_if.data.act_var);
          check_field("act_polarity", rsp_head.act_polarity, rsp_if.data.act_polarity);
          check_field("act_clause", rsp_head.act_clause, rsp_if.data.act_clause);
          check_field("lit_state", rsp_head.lit_state, rsp_if.data.lit_state);
          check_field("var_level", rsp_head.var_level, rsp_if.data.var_level);
          check_field("saved_negative", rsp_head.saved_negative,
                      rsp_if.data.saved_negative);
          check_field("decision_level", rsp_head.decision_level,
                      rsp_if.data.decision_level);
          check_field("trail_length", rsp_head.trail_length, rsp_if.data.trail_length);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned v;
    int unsigned last_taken;
    int unsigned n;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 37;
    rcv_idle_pct  = 76;
    enqueue(make_cmd(CMD_POP, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_NONE, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_APPEND, 1, 1, 0, 0, 16'h0000));
    enqueue(make_cmd(CMD_APPEND, 0, 1, 1023, 1, 16'hFFFF));
    enqueue(make_cmd(CMD_APPEND, 1, 0, 1023, 1, 16'hAAAA));
    enqueue(make_cmd(CMD_APPEND, 1, 1, 0, 1, 16'h1234));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 0, 1, 0));
    enqueue(make_cmd(CMD_QUERY, 1, 1, 1023, 0, 16'hFFFF));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 1023, 1, 0));
    enqueue(make_cmd(CMD_NONE, 1, 1, 1023, 1, 16'hFFFF));
    enqueue(make_cmd(CMD_POP, 1, 1, 1023, 1, 16'hFFFF));
    enqueue(make_cmd(CMD_POP, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 1023, 1, 0));
    enqueue(make_cmd(CMD_APPEND, 1, 1, 1023, 0, 16'h5555));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 1023, 0, 0));
    enqueue(make_cmd(CMD_POP, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_POP, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_POP, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
    enqueue(make_cmd(CMD_QUERY, 0, 0, 1023, 1, 0));
    queue_random(RANDOM_ITEMS);
    wait_drained();

    send_idle_pct = 76;
    rcv_idle_pct  = 37;
    queue_random(RANDOM_ITEMS);
    wait_drained();

    // Fill the trail to full, push past it, then unwind part of it.
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    last_taken = 0;
    for (v = 0; v < VAR_COUNT; v++) begin
      fill_taken[v] = var_set[v];
      if (var_set[v]) last_taken = v;
    end
    for (n = trail_top; n < TRAIL_DEPTH; n++) begin
      v = $urandom_range(VAR_COUNT - 1);
      if (!fill_taken[v]) begin
        fill_taken[v] = 1'b1;
        last_taken = v;
        enqueue(make_cmd(CMD_APPEND, $urandom_range(1), 1, v,
                         $urandom_range(1), $urandom()));
      end else begin
        enqueue(make_cmd(CMD_APPEND, $urandom_range(1), 0, v,
                         $urandom_range(1), $urandom()));
      end
    end
    enqueue(make_cmd(CMD_APPEND, 1, 0, 0, 0, 16'hFFFF));
    enqueue(make_cmd(CMD_APPEND, 1, 1, last_taken, 1, 16'h0F0F));
    for (v = 0; v < VAR_COUNT; v++) begin
      if (!fill_taken[v]) begin
        enqueue(make_cmd(CMD_APPEND, 0, 1, v, 0, 16'h00FF));
        break;
      end
    end
    enqueue(make_cmd(CMD_QUERY, 0, 0, last_taken, 0, 0));
    enqueue(make_cmd(CMD_QUERY, 0, 0, last_taken, 1, 0));
    for (n = 0; n < UNWIND_ITEMS; n++) begin
      enqueue(make_cmd(CMD_POP, 0, 0, 0, 0, 0));
      if (n % 16 == 0) enqueue(make_cmd(CMD_QUERY, 0, 0, pick_var(),
                                        $urandom_range(1), 0));
    end
    wait_drained();

    queue_random(RANDOM_ITEMS);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sat_at_pkg.sv
hw/rtl/sat_at_if.sv
hw/rtl/sat_at_ram.sv
hw/rtl/sat_at_ctrl.sv
hw/rtl/sat_assignment_trail_top.sv
tb/sat_assignment_trail_top_tb.sv
